/* sv/lda_topic_weight_sampler_top_defines.svh */
// Assertion macros for the sampler's RTL files.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LDA_TOPIC_WEIGHT_SAMPLER_TOP_DEFINES_SVH
`define LDA_TOPIC_WEIGHT_SAMPLER_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define LTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lts_pkg.sv */
// Shared types and constants for the LDA topic weight sampler.
// No dependencies.
package lts_pkg;

    localparam int MaxTopics = 1024;
    localparam int TopicIdxW = $clog2(MaxTopics);
    localparam int TopicCntW = $clog2(MaxTopics + 1);
    localparam int OutTopicW = 10;
    localparam int WeightW   = 48;
    localparam int TotalW    = 58;
    localparam int DivW      = 64;

    localparam logic [1:0] CfgBeta      = 2'd0;
    localparam logic [1:0] CfgBetaTotal = 2'd1;
    localparam logic [1:0] CfgAlphaTot  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_STORE,
        ST_SCALE_HI,
        ST_SCALE_LO,
        ST_WALK_RD,
        ST_WALK,
        ST_FRAC,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture input transaction, set up weight division
        logic div_step;    // one restoring-division step
        logic mul_hi;      // left * right integer part
        logic mul_lo;      // left * right fraction part, form weight
        logic store;       // write weight, accumulate
        logic scale_hi;
        logic scale_lo;
        logic walk_start;  // clear cumulative sum, issue read of entry 0
        logic walk_step;   // add read entry, compare, issue next read
        logic frac_start;  // set up word-probability division
        logic finish;      // clear token state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic total_zero;
        logic walk_hit;
        logic walk_end;
        logic is_last;
        logic frac_sat;
    } t_status;

endpackage

/* sv/lts_datapath.sv */
// Datapath: shared restoring divider, weight multiplier, weight memory, walk.
// Depends on lts_pkg and the defines header.
`include "lda_topic_weight_sampler_top_defines.svh"
module lts_datapath
    import lts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [31:0]          i_beta_smoothing,
    input  logic [31:0]          i_beta_total,
    input  logic [31:0]          i_alpha_total,
    input  logic [23:0]          i_word_topic_count,
    input  logic [23:0]          i_topic_token_count,
    input  logic [23:0]          i_doc_topic_count,
    input  logic [31:0]          i_topic_prior,
    input  logic                 i_is_current_topic,
    input  logic                 i_is_last,
    input  logic [31:0]          i_uniform_draw,
    input  logic [23:0]          i_tokens_seen,
    output logic [OutTopicW-1:0] o_sampled_topic,
    output logic [31:0]          o_word_probability,
    output logic                 o_zero_total
);

    logic [WeightW-1:0] r_mem [MaxTopics];

    logic [DivW-1:0]      r_rem, r_den, n_rem;
    logic [56:0]          r_num;      // dividend bits shifted in MSB first
    logic [56:0]          r_quo;
    logic [5:0]           r_div_cnt;
    logic [47:0]          r_right;
    logic [63:0]          r_prod_hi;
    logic                 r_cur, r_last;
    logic [31:0]          r_draw;
    logic [23:0]          r_seen;
    logic [TotalW-1:0]    r_total;
    logic [TopicCntW-1:0] r_cnt;
    logic [WeightW-1:0]   r_cur_w;
    logic [WeightW-1:0]   r_weight;
    logic [TotalW-1:0]    r_scaled;
    logic [TotalW-1:0]    r_cum;
    logic [TopicIdxW-1:0] r_rd_idx;
    logic [TopicCntW-1:0] r_walk_k;
    logic [WeightW-1:0]   r_rd_data;
    logic                 r_frac_mode, r_frac_sat;
    logic [OutTopicW-1:0] r_pick;

    logic [DivW:0]        w_trial;
    logic [63:0]          w_left;
    logic [79:0]          w_prod;
    logic [TotalW-1:0]    w_cum_next;
    logic [TopicCntW-1:0] w_last_idx;
    logic [48:0]          w_fden;

    assign w_trial    = {r_rem, r_num[56]} - {1'b0, r_den};
    assign n_rem      = w_trial[DivW] ? {r_rem[DivW-2:0], r_num[56]} : w_trial[DivW-1:0];
    assign w_left     = (r_quo > 57'hFFFF_FFFF) ? 64'hFFFF_FFFF : {7'd0, r_quo};
    assign w_prod     = {16'd0, w_left} * {48'd0, 16'(r_right[15:0])};
    assign w_cum_next = r_cum + TotalW'(r_rd_data);
    assign w_last_idx = (r_cnt == '0) ? '0 : r_cnt - 1'b1;
    assign w_fden     = {1'b0, r_seen, 16'd0} + {17'd0, i_alpha_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_cnt   <= '0;
            r_cur_w <= '0;
        end else begin
            if (i_cmd.store && r_cnt < TopicCntW'(MaxTopics)) begin
                r_total <= r_total + TotalW'(r_weight);
                r_cnt   <= r_cnt + 1'b1;
                if (r_cur) r_cur_w <= r_weight;
            end
            if (i_cmd.finish) begin
                r_total <= '0;
                r_cnt   <= '0;
                r_cur_w <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            // dividend is the Q25.16 numerator shifted up 16: 57 quotient bits
            r_rem       <= '0;
            r_num       <= {{1'b0, i_word_topic_count, 16'd0} + {9'd0, i_beta_smoothing},
                            16'd0};
            r_den       <= {24'd0, i_topic_token_count, 16'd0} + {32'd0, i_beta_total};
            r_quo       <= '0;
            r_div_cnt   <= 6'd0;
            r_frac_mode <= 1'b0;
            r_right     <= {8'd0, i_doc_topic_count, 16'd0} + {16'd0, i_topic_prior};
            r_cur       <= i_is_current_topic;
            r_last      <= i_is_last;
            r_draw      <= i_uniform_draw;
            r_seen      <= i_tokens_seen;
        end else if (i_cmd.frac_start) begin
            // cur_w / den as Q0.32: shift 48-bit remainder left 32 times
            r_rem       <= {16'd0, r_cur_w};
            r_num       <= '0;
            r_den       <= {15'd0, w_fden};
            r_quo       <= '0;
            r_div_cnt   <= 6'd0;
            r_frac_mode <= 1'b1;
            r_frac_sat  <= (w_fden == '0) || ({1'b0, r_cur_w} >= w_fden);
        end else if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_num     <= {r_num[55:0], 1'b0};
            r_quo     <= {r_quo[55:0], ~w_trial[DivW]};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.mul_hi) r_prod_hi <= w_left * {32'd0, r_right[47:16]};
        // a zero divisor gives an all-ones quotient, which saturates to the
        // same left factor, so it shares the normal multiply path
        if (i_cmd.mul_lo) begin
            if ((r_prod_hi + 64'(w_prod >> 16)) > 64'hFFFF_FFFF_FFFF) r_weight <= '1;
            else r_weight <= WeightW'(r_prod_hi + 64'(w_prod >> 16));
        end
        if (i_cmd.store && r_cnt < TopicCntW'(MaxTopics)) r_mem[r_cnt[TopicIdxW-1:0]] <= r_weight;
        if (i_cmd.scale_hi) r_prod_hi <= {38'd0, r_total[TotalW-1:32]} * {32'd0, r_draw};
        if (i_cmd.scale_lo)
            r_scaled <= TotalW'(r_prod_hi + ((64'(r_total[31:0]) * 64'(r_draw)) >> 32));
        if (i_cmd.walk_start) begin
            r_cum    <= '0;
            r_rd_idx <= '0;
            r_walk_k <= '0;
            r_pick   <= OutTopicW'(w_last_idx);
        end else if (i_cmd.walk_step) begin
            r_cum    <= w_cum_next;
            r_rd_idx <= r_rd_idx + 1'b1;
            r_walk_k <= r_walk_k + 1'b1;
            if (w_cum_next > r_scaled) r_pick <= OutTopicW'(r_walk_k);
        end
        r_rd_data <= (i_cmd.walk_start) ? r_mem[0] : r_mem[r_rd_idx + 1'b1];
    end

    assign o_status.div_done   = r_frac_mode ? (r_div_cnt == 6'd32) : (r_div_cnt == 6'd57);
    assign o_status.total_zero = (r_total == '0);
    assign o_status.walk_hit   = (w_cum_next > r_scaled);
    assign o_status.walk_end   = (r_walk_k + 1'b1 >= r_cnt);
    assign o_status.is_last    = r_last;
    assign o_status.frac_sat   = r_frac_sat;

    assign o_sampled_topic    = r_pick;
    assign o_word_probability = r_frac_sat ? 32'hFFFF_FFFF : r_quo[31:0];
    assign o_zero_total       = (r_total == '0);

    `LTS_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= TopicCntW'(MaxTopics),
        "topic count exceeds capacity")
    `LTS_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, i_cmd.finish,
        r_cnt == '0 && r_total == '0, "token state not cleared")
    `LTS_ASSERT_IMP(a_walk_range, i_clk, i_rst_n, i_cmd.walk_step, r_walk_k < r_cnt,
        "walk past stored topics")

endmodule

/* sv/lts_ctrl.sv */
// Controller state machine sequencing item processing, the sampling walk, the word-probability division and the output.
// Depends on lts_pkg.
module lts_ctrl
    import lts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_MUL_HI;
                else o_cmd.div_step = 1'b1;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state = i_status.is_last ? ST_SCALE_HI : ST_IDLE;
            end
            ST_SCALE_HI: begin
                o_cmd.scale_hi = 1'b1;
                n_state = ST_SCALE_LO;
            end
            ST_SCALE_LO: begin
                o_cmd.scale_lo = 1'b1;
                n_state = ST_WALK_RD;
            end
            ST_WALK_RD: begin
                o_cmd.walk_start = 1'b1;
                n_state = i_status.total_zero ? ST_FRAC : ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_hit || i_status.walk_end) n_state = ST_FRAC;
            end
            ST_FRAC: begin
                if (o_cmd.frac_start == 1'b0 && i_status.div_done) n_state = ST_OUT;
                else o_cmd.div_step = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_WALK_RD) o_cmd.frac_start = 1'b1;
        if (r_state == ST_WALK && n_state == ST_FRAC) o_cmd.frac_start = 1'b1;
        if (o_cmd.frac_start) o_cmd.walk_step = o_cmd.walk_step;
    end

endmodule

/* sv/lda_topic_weight_sampler_top.sv */
// Usage: one input transaction per topic, in topic order from 0. Each is
// accepted when i_in_valid is high and o_in_stall is low; stall stays high
// while the item's weight is being computed.
// Per item: the shared restoring divider (one quotient bit per cycle) and its
// done state, the two multiply states (ST_MUL_HI, ST_MUL_LO), a store state
// and a return to idle; the next input is taken only once back in idle.
// On the item marked last the block scales the draw (ST_SCALE_HI, ST_SCALE_LO),
// primes the memory read and walks the weight memory one entry per cycle, up to
// the number of stored topics (skipped on a zero total), then runs the divider
// for the word probability (32 steps and a done state). One result transaction
// is then held on the output (o_out_valid) until i_out_stall is low; no input
// is taken meanwhile. Synchronous active-low reset clears the token state and
// sets the three config registers to their defaults; the weight memory needs
// no clearing since only entries written in the current token are read.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect next cycle.
// Depends on lts_pkg, lts_ctrl, lts_datapath.
module lda_topic_weight_sampler_top
    import lts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [23:0]          i_word_topic_count,
    input  logic [23:0]          i_topic_token_count,
    input  logic [23:0]          i_doc_topic_count,
    input  logic [31:0]          i_topic_prior,
    input  logic                 i_is_current_topic,
    input  logic                 i_is_last,
    input  logic [31:0]          i_uniform_draw,
    input  logic [23:0]          i_tokens_seen,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OutTopicW-1:0] o_sampled_topic,
    output logic [31:0]          o_word_probability,
    output logic                 o_zero_total
);

    logic [31:0] r_beta, r_beta_tot, r_alpha_tot;
    t_cmd        w_cmd;
    t_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta      <= 32'd655;
            r_beta_tot  <= 32'd655360;
            r_alpha_tot <= 32'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgBeta:      r_beta      <= i_cfg_data;
                CfgBetaTotal: r_beta_tot  <= i_cfg_data;
                CfgAlphaTot:  r_alpha_tot <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    lts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_status(w_status),
        .o_cmd(w_cmd)
    );

    lts_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_beta_smoothing(r_beta), .i_beta_total(r_beta_tot), .i_alpha_total(r_alpha_tot),
        .i_word_topic_count(i_word_topic_count), .i_topic_token_count(i_topic_token_count),
        .i_doc_topic_count(i_doc_topic_count), .i_topic_prior(i_topic_prior),
        .i_is_current_topic(i_is_current_topic), .i_is_last(i_is_last),
        .i_uniform_draw(i_uniform_draw), .i_tokens_seen(i_tokens_seen),
        .o_sampled_topic(o_sampled_topic), .o_word_probability(o_word_probability),
        .o_zero_total(o_zero_total)
    );

endmodule
